### sv/hcbb_pkg.sv
// ----------------------------------------------------------------------------
// hcbb_pkg
// Types and constants shared by the canvas bounding box block.
// ----------------------------------------------------------------------------
package hcbb_pkg;

   localparam int COORD_BITS = 16;
   localparam int IN_BITS    = 48;
   localparam int DIM_BITS   = 13;
   // numerator / w width: 48b * 13b summed three times
   localparam int NUM_BITS   = 64;
   // quotient magnitude bits kept by the divider
   localparam int QUO_BITS   = COORD_BITS + 2;
   localparam int CNT_BITS   = $clog2(QUO_BITS + 1);

   localparam logic signed [COORD_BITS-1:0] CRD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CRD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [IN_BITS-1:0] h00;
      logic signed [IN_BITS-1:0] h01;
      logic signed [IN_BITS-1:0] h02;
      logic signed [IN_BITS-1:0] h10;
      logic signed [IN_BITS-1:0] h11;
      logic signed [IN_BITS-1:0] h12;
      logic signed [IN_BITS-1:0] h20;
      logic signed [IN_BITS-1:0] h21;
      logic signed [IN_BITS-1:0] h22;
      logic [DIM_BITS-1:0]       image_rows;
      logic [DIM_BITS-1:0]       image_cols;
      logic                      last_image;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] img_min_x;
      logic signed [COORD_BITS-1:0] img_min_y;
      logic signed [COORD_BITS-1:0] img_max_x;
      logic signed [COORD_BITS-1:0] img_max_y;
      logic [COORD_BITS:0]          span_x;
      logic [COORD_BITS:0]          span_y;
      logic signed [COORD_BITS-1:0] offset_x;
      logic signed [COORD_BITS-1:0] offset_y;
      logic                         bad_projection;
   } rsp_type;

   // divider result toward the sequencer
   typedef struct packed {
      logic                         done;
      logic signed [COORD_BITS-1:0] fl;
      logic signed [COORD_BITS-1:0] ce;
      logic                         bad;
   } div_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_FOLD,
      ST_OUT
   } state_type;

endpackage

### sv/hcbb_div.sv
// ----------------------------------------------------------------------------
// hcbb_div
// Restoring divider: floor and ceiling of num / w, clamped to coordinates.
// ----------------------------------------------------------------------------
module hcbb_div
   import hcbb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic signed [NUM_BITS-1:0] den,
   output div_res_type                res
);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] rem_ff, rem_in;     // remaining magnitude
   logic [NUM_BITS-1:0] den_ff, den_in;     // positive divisor
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic                big_ff, big_in;     // quotient too large to track
   logic                fin_ff, fin_in;
   logic                spec_ff, spec_in;   // nonpositive w
   logic signed [COORD_BITS-1:0] sat_ff, sat_in;

   logic [NUM_BITS-1:0] mag;
   logic [NUM_BITS-1:0] trial;
   logic [NUM_BITS-1:0] shf;
   logic signed [QUO_BITS+1:0] qf, qc, qs;
   logic                exact;

   always_comb begin
      mag = num[NUM_BITS-1] ? (~num + 1'b1) : num;
   end

   // one quotient bit a cycle, msb first
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      big_in  = big_ff;
      spec_in = spec_ff;
      sat_in  = sat_ff;
      fin_in  = 1'b0;
      shf     = '0;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QUO_BITS);
         rem_in  = mag;
         den_in  = den;
         quo_in  = '0;
         neg_in  = num[NUM_BITS-1];
         spec_in = (den[NUM_BITS-1] || den == '0);
         sat_in  = num[NUM_BITS-1] ? CRD_LO : ((num == '0) ? '0 : CRD_HI);
         // quotient >= 2^QUO_BITS when mag >> QUO_BITS >= den
         big_in  = ((mag >> QUO_BITS) >= den);
      end else if (busy_ff) begin
         if (spec_ff || big_ff || cnt_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            shf   = den_ff << (cnt_ff - 1'b1);
            trial = rem_ff - shf;
            if ((rem_ff >> (cnt_ff - 1'b1)) >= den_ff) begin
               rem_in = trial;
               quo_in = quo_ff | (QUO_BITS'(1) << (cnt_ff - 1'b1));
            end
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      big_ff  <= big_in;
      spec_ff <= spec_in;
      sat_ff  <= sat_in;
   end

   // signed floor and ceiling, then clamp
   always_comb begin
      exact = (rem_ff == '0);
      qs = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      qf = (neg_ff && !exact) ? qs - 1'b1 : qs;
      qc = (!neg_ff && !exact) ? qs + 1'b1 : qs;
      res.done = fin_ff;
      res.bad  = 1'b0;
      if (spec_ff) begin
         res.fl  = sat_ff;
         res.ce  = sat_ff;
         res.bad = 1'b1;
      end else if (big_ff) begin
         res.fl  = neg_ff ? CRD_LO : CRD_HI;
         res.ce  = res.fl;
         res.bad = 1'b1;
      end else begin
         res.fl = qf[COORD_BITS-1:0];
         res.ce = qc[COORD_BITS-1:0];
         if (qf < $signed(CRD_LO)) begin res.fl = CRD_LO; res.bad = 1'b1; end
         if (qf > $signed(CRD_HI)) begin res.fl = CRD_HI; res.bad = 1'b1; end
         if (qc < $signed(CRD_LO)) begin res.ce = CRD_LO; res.bad = 1'b1; end
         if (qc > $signed(CRD_HI)) begin res.ce = CRD_HI; res.bad = 1'b1; end
      end
   end

endmodule

### sv/homography_canvas_bounding_box.sv
// ----------------------------------------------------------------------------
// homography_canvas_bounding_box
// Projects four image corners, bounds them and folds into a running canvas.
// ----------------------------------------------------------------------------
// Sequence: per corner the matrix column products are accumulated, then two
// divisions (x, then y) run on one shared restoring divider, ending early when w
// is nonpositive or the quotient is huge; the response follows the final fold.
// Throughput: one transaction at a time; req_stall is high until rsp is taken.
// Reset: synchronous, clears control and returns the canvas box to min 32767,
// max 0.
module homography_canvas_bounding_box
   import hcbb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [1:0] corner_ff, corner_in;
   logic [1:0] term_ff, term_in;     // product term in mac, 0..2
   logic       axis_ff, axis_in;     // 0 = x division, 1 = y
   logic       start_ff, start_in;
   logic signed [NUM_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in, w_ff, w_in;
   logic signed [COORD_BITS-1:0] mnx_ff, mnx_in, mny_ff, mny_in;
   logic signed [COORD_BITS-1:0] mxx_ff, mxx_in, mxy_ff, mxy_in;
   logic bad_ff, bad_in;
   logic signed [COORD_BITS-1:0] cmnx_ff, cmnx_in, cmny_ff, cmny_in;
   logic signed [COORD_BITS-1:0] cmxx_ff, cmxx_in, cmxy_ff, cmxy_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [IN_BITS-1:0]  ha, hb, hc;
   logic signed [DIM_BITS:0]   crd;
   logic signed [NUM_BITS-1:0] pa, pb, pc;
   logic [DIM_BITS-1:0] cx, cy;
   div_res_type dres;

   hcbb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (axis_ff ? ny_ff : nx_ff),
      .den   (w_ff),
      .res   (dres)
   );

   // corner coordinates
   always_comb begin
      cx = (corner_ff == 2'd1 || corner_ff == 2'd2) ? req_ff.image_cols : '0;
      cy = (corner_ff == 2'd2 || corner_ff == 2'd3) ? req_ff.image_rows : '0;
   end

   // shared multiply: one column of the matrix per cycle (x, y, w rows)
   always_comb begin
      case (term_ff)
         2'd0: begin
            ha = req_ff.h00; hb = req_ff.h10; hc = req_ff.h20;
            crd = $signed({1'b0, cx});
         end
         2'd1: begin
            ha = req_ff.h01; hb = req_ff.h11; hc = req_ff.h21;
            crd = $signed({1'b0, cy});
         end
         default: begin
            ha = req_ff.h02; hb = req_ff.h12; hc = req_ff.h22;
            crd = $signed({{DIM_BITS{1'b0}}, 1'b1});
         end
      endcase
      pa = NUM_BITS'(ha * crd);
      pb = NUM_BITS'(hb * crd);
      pc = NUM_BITS'(hc * crd);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      term_in   = term_ff;
      axis_in   = axis_ff;
      start_in  = 1'b0;
      nx_in = nx_ff; ny_in = ny_ff; w_in = w_ff;
      mnx_in = mnx_ff; mny_in = mny_ff; mxx_in = mxx_ff; mxy_in = mxy_ff;
      bad_in = bad_ff;
      cmnx_in = cmnx_ff; cmny_in = cmny_ff; cmxx_in = cmxx_ff; cmxy_in = cmxy_ff;
      rsp_in = rsp_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_MAC;
               corner_in = '0;
               term_in   = '0;
               nx_in = '0; ny_in = '0; w_in = '0;
               mnx_in = CRD_HI; mny_in = CRD_HI; mxx_in = CRD_LO; mxy_in = CRD_LO;
               bad_in = 1'b0;
            end
         end
         ST_MAC: begin
            nx_in = nx_ff + pa;
            ny_in = ny_ff + pb;
            w_in  = w_ff + pc;
            if (term_ff == 2'd2) begin
               state_in = ST_DIV;
               axis_in  = 1'b0;
               start_in = 1'b1;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (dres.done) begin
               bad_in = bad_ff | dres.bad;
               if (!axis_ff) begin
                  if (dres.fl < mnx_ff) mnx_in = dres.fl;
                  if (dres.ce > mxx_ff) mxx_in = dres.ce;
                  axis_in  = 1'b1;
                  start_in = 1'b1;
               end else begin
                  if (dres.fl < mny_ff) mny_in = dres.fl;
                  if (dres.ce > mxy_ff) mxy_in = dres.ce;
                  if (corner_ff == 2'd3) begin
                     state_in = ST_FOLD;
                  end else begin
                     corner_in = corner_ff + 1'b1;
                     term_in   = '0;
                     nx_in = '0; ny_in = '0; w_in = '0;
                     state_in  = ST_MAC;
                  end
               end
            end
         end
         ST_FOLD: begin
            if (mnx_ff < cmnx_ff) cmnx_in = mnx_ff;
            if (mny_ff < cmny_ff) cmny_in = mny_ff;
            if (mxx_ff > cmxx_ff) cmxx_in = mxx_ff;
            if (mxy_ff > cmxy_ff) cmxy_in = mxy_ff;
            rsp_in.img_min_x = mnx_ff;
            rsp_in.img_min_y = mny_ff;
            rsp_in.img_max_x = mxx_ff;
            rsp_in.img_max_y = mxy_ff;
            rsp_in.span_x = (COORD_BITS+1)'(
               {cmxx_in[COORD_BITS-1], cmxx_in} - {cmnx_in[COORD_BITS-1], cmnx_in} + 1'b1);
            rsp_in.span_y = (COORD_BITS+1)'(
               {cmxy_in[COORD_BITS-1], cmxy_in} - {cmny_in[COORD_BITS-1], cmny_in} + 1'b1);
            rsp_in.offset_x = cmnx_in;
            rsp_in.offset_y = cmny_in;
            rsp_in.bad_projection = bad_ff;
            if (req_ff.last_image) begin
               cmnx_in = CRD_HI; cmny_in = CRD_HI; cmxx_in = '0; cmxy_in = '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         cmnx_ff  <= CRD_HI;
         cmny_ff  <= CRD_HI;
         cmxx_ff  <= '0;
         cmxy_ff  <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         cmnx_ff  <= cmnx_in;
         cmny_ff  <= cmny_in;
         cmxx_ff  <= cmxx_in;
         cmxy_ff  <= cmxy_in;
      end
      if (state_ff == ST_IDLE && req_valid) req_ff <= req_data;
      corner_ff <= corner_in;
      term_ff   <= term_in;
      axis_ff   <= axis_in;
      nx_ff <= nx_in; ny_ff <= ny_in; w_ff <= w_in;
      mnx_ff <= mnx_in; mny_ff <= mny_in; mxx_ff <= mxx_in; mxy_ff <= mxy_in;
      bad_ff <= bad_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   // checks
   a_canvas_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (rsp_ff.span_x != '0))
      else $error("canvas width zero");
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> !start_ff)
      else $error("divider restarted back to back");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      dres.done |-> (state_ff == ST_DIV))
      else $error("divider result outside divide state");

endmodule
